### sv/assert_macros.svh
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/gcd_pkg.sv
package gcd_pkg;

    localparam int CORDIC_STEPS    = 32;
    localparam int ITER_W          = $clog2(CORDIC_STEPS);
    localparam int EARTH_RADIUS_KM = 6371;
    localparam int EARTH_RADIUS_M  = EARTH_RADIUS_KM * 1000;

    // CORDIC datapath width and multiplier operand width.
    localparam int CW = 36;
    localparam int MW = 36;
    localparam int PW = 2 * MW;

    localparam logic [31:0] PI_Q30   = 32'd3373259426;
    localparam logic [31:0] K_Q30    = 32'd652032874;
    // Degrees to binary angle: floor(mag * 2^22 / BAM_DIV).
    localparam logic [31:0] BAM_DIV   = 32'd3515625;
    localparam logic [35:0] BAM_RECIP = 36'((64'd1 << 54) / 64'd3515625);
    localparam logic [16:0] GAIN_ONE = 17'd65536;
    localparam logic [27:0] OUT_MAX  = 28'd200150000;
    localparam int STATE_W = 42;

    localparam logic signed [CW-1:0] ATAN_HEAD [10] = '{
        CW'(843314857), CW'(497837829), CW'(263043837), CW'(133525159), CW'(67021687),
        CW'(33543516), CW'(16775851), CW'(8388437), CW'(4194283), CW'(2097149)
    };

    typedef enum logic [4:0] {
        ST_IDLE, ST_CONV_A, ST_CONV_B, ST_CONV_C, ST_ZMUL, ST_ZLOAD, ST_ROT, ST_ROT_END,
        ST_PROD_A, ST_PROD_B, ST_VEC1_LOAD, ST_VEC1, ST_MAGK_A, ST_MAGK_B, ST_VEC2,
        ST_THETA, ST_DIST_A, ST_DIST_B, ST_FILT_LO, ST_FILT_HI, ST_FILT_SUM, ST_EMIT
    } t_state;

    typedef struct packed {
        logic              load;
        logic              step;
        logic              vec;
        logic [ITER_W-1:0] iter;
    } t_cordic_ctl;

    function automatic logic signed [CW-1:0] atan_step(input logic [ITER_W-1:0] i);
        logic signed [CW-1:0] v;
        v = '0;
        if (int'(i) < 10) begin
            v = ATAN_HEAD[i[3:0]];
        end else if (int'(i) <= 30) begin
            v = {{(CW-1){1'b0}}, 1'b1} << (30 - int'(i));
        end
        return v;
    endfunction

endpackage

### sv/gcd_mult.sv
module gcd_mult (
    input  logic                             i_clk,
    input  logic signed [gcd_pkg::MW-1:0]    i_a,
    input  logic signed [gcd_pkg::MW-1:0]    i_b,
    output logic signed [gcd_pkg::PW-1:0]    o_p
);

    logic signed [gcd_pkg::PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

### sv/gcd_cordic.sv
module gcd_cordic (
    input  logic                          i_clk,
    input  gcd_pkg::t_cordic_ctl          i_ctl,
    input  logic signed [gcd_pkg::CW-1:0] i_x,
    input  logic signed [gcd_pkg::CW-1:0] i_y,
    input  logic signed [gcd_pkg::CW-1:0] i_z,
    output logic signed [gcd_pkg::CW-1:0] o_x,
    output logic signed [gcd_pkg::CW-1:0] o_y,
    output logic signed [gcd_pkg::CW-1:0] o_z
);

    logic signed [gcd_pkg::CW-1:0] r_x, r_y, r_z;
    logic signed [gcd_pkg::CW-1:0] n_x, n_y, n_z;
    logic signed [gcd_pkg::CW-1:0] w_xs, w_ys, w_a;
    logic                          w_ccw;

    // One micro-rotation. Rotation mode steers by the sign of z, vectoring
    // mode drives y toward zero.
    always_comb begin
        w_xs  = r_x >>> i_ctl.iter;
        w_ys  = r_y >>> i_ctl.iter;
        w_a   = gcd_pkg::atan_step(i_ctl.iter);
        w_ccw = i_ctl.vec ? !(r_y > 0) : (r_z >= 0);
        n_x   = w_ccw ? r_x - w_ys : r_x + w_ys;
        n_y   = w_ccw ? r_y + w_xs : r_y - w_xs;
        n_z   = w_ccw ? r_z - w_a : r_z + w_a;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_x <= i_x;
            r_y <= i_y;
            r_z <= i_z;
        end else if (i_ctl.step) begin
            r_x <= n_x;
            r_y <= n_y;
            r_z <= n_z;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule

### sv/great_circle_distance_lpf.sv
// The CORDIC unit makes five passes per transaction, three rotations and two vectoring passes;
// the second vectoring pass is skipped when the two positions give a zero chord.
// One transaction at a time: input ready only while idle.
// Reset (synchronous, active low) clears the filter state, sets the gain to 65536
// and empties the output register.
module great_circle_distance_lpf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [30:0] i_cur_latitude,
    input  logic signed [31:0] i_cur_longitude,
    input  logic signed [30:0] i_target_latitude,
    input  logic signed [31:0] i_target_longitude,
    output logic               o_valid,
    input  logic               i_ready,
    output logic        [27:0] o_distance_dm,
    input  logic               i_cfg_we,
    input  logic        [16:0] i_cfg_wdata
);

    `include "assert_macros.svh"

    localparam int CW = gcd_pkg::CW;
    localparam int MW = gcd_pkg::MW;
    localparam int PW = gcd_pkg::PW;

    gcd_pkg::t_state r_state, n_state;

    // Latched input transaction.
    logic signed [30:0] r_clat, r_tlat;
    logic signed [31:0] r_clon, r_tlon;

    logic [2:0]                  r_idx;
    logic [gcd_pkg::ITER_W-1:0]  r_iter;
    logic [1:0]                  r_quad;
    logic [31:0]                 r_qest;
    logic [31:0]                 r_bam_lc, r_bam_cl, r_bam_lt, r_bam_tl;
    logic signed [CW-1:0]        r_cc, r_sc, r_ct, r_st, r_cd, r_sd;
    logic signed [CW-1:0]        r_n1, r_n2, r_den, r_t, r_t2;
    logic [31:0]                 r_theta;
    logic signed [43:0]          r_diff;
    logic [38:0]                 r_plo;
    logic [gcd_pkg::STATE_W-1:0] r_filt;
    logic [16:0]                 r_gain;
    logic                        r_out_valid;
    logic [27:0]                 r_out;

    // Shared multiplier and CORDIC unit.
    logic signed [MW-1:0]  w_mul_a, w_mul_b;
    logic signed [PW-1:0]  r_prod;
    gcd_pkg::t_cordic_ctl  w_cctl;
    logic signed [CW-1:0]  w_cx, w_cy, w_cz;
    logic signed [CW-1:0]  c_x, c_y, c_z;

    gcd_mult u_mult (
        .i_clk (i_clk),
        .i_a   (w_mul_a),
        .i_b   (w_mul_b),
        .o_p   (r_prod)
    );

    gcd_cordic u_cordic (
        .i_clk (i_clk),
        .i_ctl (w_cctl),
        .i_x   (w_cx),
        .i_y   (w_cy),
        .i_z   (w_cz),
        .o_x   (c_x),
        .o_y   (c_y),
        .o_z   (c_z)
    );

    // Datapath helpers.
    logic [31:0]          w_conv_x, w_conv_mag, w_q, w_bam, w_sc_bam;
    logic                 w_conv_neg;
    logic [53:0]          w_rem;
    logic signed [CW-1:0] w_mul30, w_c, w_s;
    logic signed [CW-1:0] w_abs_n1, w_abs_n2, w_abs_den;
    logic signed [CW:0]   w_pi, w_th;
    logic [42:0]          w_d;
    logic [16:0]          w_gain;
    logic signed [63:0]   w_total;
    logic signed [45:0]   w_s_new;
    logic [45:0]          w_s10;
    logic [29:0]          w_dm;
    logic                 w_last_iter;

    always_comb begin
        case (r_idx[1:0])
            2'd0:    w_conv_x = {r_clat[30], r_clat};
            2'd1:    w_conv_x = r_clon;
            2'd2:    w_conv_x = {r_tlat[30], r_tlat};
            default: w_conv_x = r_tlon;
        endcase
        w_conv_neg = w_conv_x[31];
        w_conv_mag = w_conv_neg ? 32'd0 - w_conv_x : w_conv_x;
        // The reciprocal estimate is at most one low; the remainder fixes it.
        w_rem = {w_conv_mag, 22'd0} - r_prod[53:0];
        w_q   = r_qest + 32'(w_rem >= 54'(gcd_pkg::BAM_DIV));
        w_bam = w_conv_neg ? 32'd0 - w_q : w_q;

        case (r_idx[1:0])
            2'd0:    w_sc_bam = r_bam_lc;
            2'd1:    w_sc_bam = r_bam_lt;
            default: w_sc_bam = r_bam_tl - r_bam_cl;
        endcase

        w_mul30 = r_prod[CW+29:30];

        // Fold the first-quadrant CORDIC result back to the full circle.
        case (r_quad)
            2'd0: begin
                w_c = c_x;
                w_s = c_y;
            end
            2'd1: begin
                w_c = -c_y;
                w_s = c_x;
            end
            2'd2: begin
                w_c = -c_x;
                w_s = -c_y;
            end
            default: begin
                w_c = c_y;
                w_s = -c_x;
            end
        endcase

        w_abs_n1  = r_n1[CW-1] ? -r_n1 : r_n1;
        w_abs_n2  = r_n2[CW-1] ? -r_n2 : r_n2;
        w_abs_den = r_den[CW-1] ? -r_den : r_den;

        // A negative denominator puts the angle in the second quadrant.
        w_pi = $signed((CW+1)'(gcd_pkg::PI_Q30));
        w_th = r_den[CW-1] ? w_pi - $signed({c_z[CW-1], c_z}) : $signed({c_z[CW-1], c_z});

        w_d     = r_prod[56:14];
        w_gain  = (r_gain > gcd_pkg::GAIN_ONE) ? gcd_pkg::GAIN_ONE : r_gain;
        w_total = ($signed(r_prod[63:0]) <<< 22) + $signed(64'(r_plo));
        w_s_new = $signed({4'd0, r_filt}) + 46'(w_total >>> 16);

        w_s10 = ({4'd0, r_filt} << 3) + ({4'd0, r_filt} << 1);
        w_dm  = w_s10[45:16];

        w_last_iter = (r_iter == gcd_pkg::ITER_W'(gcd_pkg::CORDIC_STEPS - 1));
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            gcd_pkg::ST_IDLE:      if (i_valid) n_state = gcd_pkg::ST_CONV_A;
            gcd_pkg::ST_CONV_A:    n_state = gcd_pkg::ST_CONV_B;
            gcd_pkg::ST_CONV_B:    n_state = gcd_pkg::ST_CONV_C;
            gcd_pkg::ST_CONV_C: begin
                n_state = (r_idx == 3'd3) ? gcd_pkg::ST_ZMUL : gcd_pkg::ST_CONV_A;
            end
            gcd_pkg::ST_ZMUL:      n_state = gcd_pkg::ST_ZLOAD;
            gcd_pkg::ST_ZLOAD:     n_state = gcd_pkg::ST_ROT;
            gcd_pkg::ST_ROT:       if (w_last_iter) n_state = gcd_pkg::ST_ROT_END;
            gcd_pkg::ST_ROT_END: begin
                n_state = (r_idx == 3'd2) ? gcd_pkg::ST_PROD_A : gcd_pkg::ST_ZMUL;
            end
            gcd_pkg::ST_PROD_A:    n_state = gcd_pkg::ST_PROD_B;
            gcd_pkg::ST_PROD_B: begin
                n_state = (r_idx == 3'd6) ? gcd_pkg::ST_VEC1_LOAD : gcd_pkg::ST_PROD_A;
            end
            gcd_pkg::ST_VEC1_LOAD: n_state = gcd_pkg::ST_VEC1;
            gcd_pkg::ST_VEC1:      if (w_last_iter) n_state = gcd_pkg::ST_MAGK_A;
            gcd_pkg::ST_MAGK_A:    n_state = gcd_pkg::ST_MAGK_B;
            gcd_pkg::ST_MAGK_B: begin
                n_state = (w_mul30 > 0) ? gcd_pkg::ST_VEC2 : gcd_pkg::ST_DIST_A;
            end
            gcd_pkg::ST_VEC2:      if (w_last_iter) n_state = gcd_pkg::ST_THETA;
            gcd_pkg::ST_THETA:     n_state = gcd_pkg::ST_DIST_A;
            gcd_pkg::ST_DIST_A:    n_state = gcd_pkg::ST_DIST_B;
            gcd_pkg::ST_DIST_B:    n_state = gcd_pkg::ST_FILT_LO;
            gcd_pkg::ST_FILT_LO:   n_state = gcd_pkg::ST_FILT_HI;
            gcd_pkg::ST_FILT_HI:   n_state = gcd_pkg::ST_FILT_SUM;
            gcd_pkg::ST_FILT_SUM:  n_state = gcd_pkg::ST_EMIT;
            gcd_pkg::ST_EMIT:      if (!r_out_valid || i_ready) n_state = gcd_pkg::ST_IDLE;
            default:               n_state = gcd_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: multiplier operands, CORDIC commands and ready.
    always_comb begin
        o_ready     = (r_state == gcd_pkg::ST_IDLE);
        w_mul_a     = '0;
        w_mul_b     = '0;
        w_cctl.load = 1'b0;
        w_cctl.step = 1'b0;
        w_cctl.vec  = 1'b0;
        w_cctl.iter = r_iter;
        w_cx        = '0;
        w_cy        = '0;
        w_cz        = '0;
        case (r_state)
            gcd_pkg::ST_CONV_A: begin
                w_mul_a = $signed(MW'(w_conv_mag));
                w_mul_b = $signed(MW'(gcd_pkg::BAM_RECIP));
            end
            gcd_pkg::ST_CONV_B: begin
                w_mul_a = $signed(MW'(r_prod[63:32]));
                w_mul_b = $signed(MW'(gcd_pkg::BAM_DIV));
            end
            gcd_pkg::ST_ZMUL: begin
                w_mul_a = $signed(MW'(w_sc_bam[29:0]));
                w_mul_b = $signed(MW'(gcd_pkg::PI_Q30));
            end
            gcd_pkg::ST_ZLOAD: begin
                w_cctl.load = 1'b1;
                w_cx        = $signed(CW'(gcd_pkg::K_Q30));
                w_cz        = $signed(CW'(r_prod[61:31]));
            end
            gcd_pkg::ST_ROT: begin
                w_cctl.step = 1'b1;
            end
            gcd_pkg::ST_PROD_A: begin
                case (r_idx)
                    3'd0: begin
                        w_mul_a = r_ct;
                        w_mul_b = r_sd;
                    end
                    3'd1: begin
                        w_mul_a = r_cc;
                        w_mul_b = r_st;
                    end
                    3'd2: begin
                        w_mul_a = r_sc;
                        w_mul_b = r_ct;
                    end
                    3'd4: begin
                        w_mul_a = r_sc;
                        w_mul_b = r_st;
                    end
                    3'd5: begin
                        w_mul_a = r_cc;
                        w_mul_b = r_ct;
                    end
                    default: begin
                        w_mul_a = r_t;
                        w_mul_b = r_cd;
                    end
                endcase
            end
            gcd_pkg::ST_VEC1_LOAD: begin
                w_cctl.load = 1'b1;
                w_cx        = w_abs_n2;
                w_cy        = w_abs_n1;
            end
            gcd_pkg::ST_VEC1, gcd_pkg::ST_VEC2: begin
                w_cctl.step = 1'b1;
                w_cctl.vec  = 1'b1;
            end
            gcd_pkg::ST_MAGK_A: begin
                w_mul_a = c_x;
                w_mul_b = $signed(MW'(gcd_pkg::K_Q30));
            end
            gcd_pkg::ST_MAGK_B: begin
                w_cctl.load = 1'b1;
                w_cx        = w_abs_den;
                w_cy        = w_mul30;
            end
            gcd_pkg::ST_DIST_A: begin
                w_mul_a = $signed(MW'(r_theta));
                w_mul_b = $signed(MW'(gcd_pkg::EARTH_RADIUS_M));
            end
            gcd_pkg::ST_FILT_LO: begin
                w_mul_a = $signed(MW'(r_diff[21:0]));
                w_mul_b = $signed(MW'(w_gain));
            end
            gcd_pkg::ST_FILT_HI: begin
                // The upper slice carries the sign of the difference.
                w_mul_a = MW'($signed(r_diff[43:22]));
                w_mul_b = $signed(MW'(w_gain));
            end
            default: begin
                w_mul_a = '0;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcd_pkg::ST_IDLE;
            r_idx       <= '0;
            r_iter      <= '0;
            r_filt      <= '0;
            r_gain      <= gcd_pkg::GAIN_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_gain <= i_cfg_wdata;
            end
            case (r_state)
                gcd_pkg::ST_IDLE: r_idx <= '0;
                gcd_pkg::ST_CONV_C: r_idx <= (r_idx == 3'd3) ? 3'd0 : r_idx + 3'd1;
                gcd_pkg::ST_ROT_END: r_idx <= (r_idx == 3'd2) ? 3'd0 : r_idx + 3'd1;
                gcd_pkg::ST_PROD_B: r_idx <= r_idx + 3'd1;
                default: r_idx <= r_idx;
            endcase
            case (r_state)
                gcd_pkg::ST_ROT, gcd_pkg::ST_VEC1, gcd_pkg::ST_VEC2: r_iter <= r_iter + 1'b1;
                default: r_iter <= '0;
            endcase
            if (r_state == gcd_pkg::ST_FILT_SUM) begin
                r_filt <= w_s_new[45] ? '0 : w_s_new[gcd_pkg::STATE_W-1:0];
            end
            if (r_state == gcd_pkg::ST_EMIT && (!r_out_valid || i_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (r_state == gcd_pkg::ST_IDLE && i_valid) begin
            r_clat <= i_cur_latitude;
            r_clon <= i_cur_longitude;
            r_tlat <= i_target_latitude;
            r_tlon <= i_target_longitude;
        end
        case (r_state)
            gcd_pkg::ST_CONV_B: r_qest <= r_prod[63:32];
            gcd_pkg::ST_CONV_C: begin
                case (r_idx[1:0])
                    2'd0:    r_bam_lc <= w_bam;
                    2'd1:    r_bam_cl <= w_bam;
                    2'd2:    r_bam_lt <= w_bam;
                    default: r_bam_tl <= w_bam;
                endcase
            end
            gcd_pkg::ST_ZMUL: r_quad <= w_sc_bam[31:30];
            gcd_pkg::ST_ROT_END: begin
                case (r_idx[1:0])
                    2'd0: begin
                        r_cc <= w_c;
                        r_sc <= w_s;
                    end
                    2'd1: begin
                        r_ct <= w_c;
                        r_st <= w_s;
                    end
                    default: begin
                        r_cd <= w_c;
                        r_sd <= w_s;
                    end
                endcase
            end
            gcd_pkg::ST_PROD_B: begin
                case (r_idx)
                    3'd0:    r_n1  <= w_mul30;
                    3'd1:    r_t2  <= w_mul30;
                    3'd2:    r_t   <= w_mul30;
                    3'd3:    r_n2  <= r_t2 - w_mul30;
                    3'd4:    r_t2  <= w_mul30;
                    3'd5:    r_t   <= w_mul30;
                    default: r_den <= r_t2 + w_mul30;
                endcase
            end
            gcd_pkg::ST_MAGK_B: begin
                // With a zero chord the angle is 0 or pi straight away.
                r_theta <= r_den[CW-1] ? gcd_pkg::PI_Q30 : 32'd0;
            end
            gcd_pkg::ST_THETA: begin
                if (w_th < 0) begin
                    r_theta <= 32'd0;
                end else if (w_th > w_pi) begin
                    r_theta <= gcd_pkg::PI_Q30;
                end else begin
                    r_theta <= w_th[31:0];
                end
            end
            gcd_pkg::ST_DIST_B: begin
                r_diff <= $signed({1'b0, w_d}) - $signed({2'b0, r_filt});
            end
            gcd_pkg::ST_FILT_HI: r_plo <= r_prod[38:0];
            gcd_pkg::ST_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    r_out <= (w_dm > 30'(gcd_pkg::OUT_MAX)) ? gcd_pkg::OUT_MAX : w_dm[27:0];
                end
            end
            default: r_qest <= r_qest;
        endcase
    end

    assign o_valid       = r_out_valid;
    assign o_distance_dm = r_out;

    `ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `ASSERT_IMPLIES(a_theta_range, i_clk, i_rst_n, r_state == gcd_pkg::ST_DIST_A,
        r_theta <= gcd_pkg::PI_Q30)
    `ASSERT_IMPLIES(a_out_range, i_clk, i_rst_n, o_valid, o_distance_dm <= gcd_pkg::OUT_MAX)
    `ASSERT_IMPLIES(a_vec_x_pos, i_clk, i_rst_n, r_state == gcd_pkg::ST_VEC1, c_x >= 0)

endmodule
